@@ src/msp_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the MSP v1/v2 frame decoder.
// No dependencies; used by the parser, the config registers and the top level.
package msp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned APB_AW  = 3;
    localparam int unsigned APB_DW  = 32;

    localparam logic [LEN_W-1:0] MAX_V2_RESET = 16'd4096;

    // register word index
    localparam logic REG_MAX_V2 = 1'b0;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CSUM_OK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CSUM_BAD = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  byte_index;
        logic [LEN_W-1:0]  command_code;
        logic [LEN_W-1:0]  payload_length;
        logic              is_version2;
        logic              direction;
        logic              unsupported;
    } t_result;

endpackage

@@ src/msp_cfg.sv @@
`timescale 1ns / 1ps
// APB-style configuration register file: holds the v2 payload length limit.
// Depends on msp_pkg.
module msp_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msp_pkg::APB_AW-1:0]    paddr,
    input  logic [msp_pkg::APB_DW-1:0]    pwdata,
    output logic [msp_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output logic [msp_pkg::LEN_W-1:0]     o_max_v2
);

    logic [msp_pkg::LEN_W-1:0] r_max_v2;
    logic                      reg_hit;

    assign reg_hit = (paddr[msp_pkg::APB_AW-1] == msp_pkg::REG_MAX_V2);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_v2 <= msp_pkg::MAX_V2_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_max_v2 <= pwdata[msp_pkg::LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_hit) begin
            prdata[msp_pkg::LEN_W-1:0] = r_max_v2;
        end
    end

    assign o_max_v2 = r_max_v2;

endmodule

@@ src/msp_parser.sv @@
`timescale 1ns / 1ps
// Frame parse state machine: one byte per fire, XOR / CRC-8 (0xD5) checksum,
// produces at most one result per byte. Depends on msp_pkg.
module msp_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [msp_pkg::BYTE_W-1:0]    i_byte,
    input  logic [msp_pkg::LEN_W-1:0]     i_max_v2,
    output logic                          o_res_valid,
    output msp_pkg::t_result              o_res
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_PROTO, PH_DIR_V1, PH_DIR_V2, PH_FLAG_V2, PH_LEN_V1,
        PH_CODE_V1, PH_CODE_JUMBO, PH_JLEN_LO, PH_JLEN_HI, PH_PAY_V1,
        PH_CODE_V2_LO, PH_CODE_V2_HI, PH_LEN_V2_LO, PH_LEN_V2_HI, PH_PAY_V2,
        PH_CSUM_V1, PH_CSUM_V2
    } t_phase;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] JUMBO_LEN = 8'd255;
    localparam logic [7:0] CRC_POLY  = 8'hD5;

    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    t_phase                    r_phase, n_phase;
    logic [msp_pkg::LEN_W-1:0] r_exp_len, n_exp_len;
    logic [msp_pkg::LEN_W-1:0] r_rx_cnt, n_rx_cnt;
    logic [msp_pkg::LEN_W-1:0] r_code, n_code;
    logic [7:0]                r_csum, n_csum;
    logic [7:0]                r_flag, n_flag;
    logic                      r_dir, n_dir;
    logic                      r_unsup, n_unsup;

    logic [msp_pkg::LEN_W-1:0] cnt_inc;
    logic [msp_pkg::LEN_W-1:0] len_v2;
    logic [msp_pkg::LEN_W-1:0] len_jumbo;
    logic [7:0]                crc_b;

    assign cnt_inc   = r_rx_cnt + 1'b1;
    assign len_v2    = {i_byte, r_exp_len[7:0]};
    assign len_jumbo = {i_byte, r_exp_len[7:0]};
    assign crc_b     = crc_step(r_csum, i_byte);

    always_comb begin
        n_phase     = r_phase;
        n_exp_len   = r_exp_len;
        n_rx_cnt    = r_rx_cnt;
        n_code      = r_code;
        n_csum      = r_csum;
        n_flag      = r_flag;
        n_dir       = r_dir;
        n_unsup     = r_unsup;
        o_res_valid = 1'b0;

        o_res.kind           = msp_pkg::KIND_PAYLOAD;
        o_res.payload_byte   = i_byte;
        o_res.byte_index     = r_rx_cnt;
        o_res.command_code   = r_code;
        o_res.payload_length = r_exp_len;
        o_res.is_version2    = (r_phase == PH_PAY_V2) || (r_phase == PH_CSUM_V2);
        o_res.direction      = r_dir;
        o_res.unsupported    = r_unsup;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_byte == CH_DOLLAR) begin
                    n_csum  = '0;
                    n_phase = PH_PROTO;
                end
            end
            PH_PROTO: begin
                if (i_byte == CH_M) begin
                    n_phase = PH_DIR_V1;
                end else if (i_byte == CH_X) begin
                    n_phase = PH_DIR_V2;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_DIR_V1, PH_DIR_V2: begin
                n_unsup = 1'b0;
                if (i_byte == CH_GT) begin
                    n_dir = 1'b1;
                end else if (i_byte == CH_LT) begin
                    n_dir = 1'b0;
                end else if (i_byte == CH_BANG) begin
                    n_unsup = 1'b1;
                end
                n_phase = (r_phase == PH_DIR_V1) ? PH_LEN_V1 : PH_FLAG_V2;
            end
            PH_FLAG_V2: begin
                n_flag  = i_byte;
                n_csum  = crc_step(8'd0, i_byte);
                n_phase = PH_CODE_V2_LO;
            end
            PH_LEN_V1: begin
                n_exp_len = {8'd0, i_byte};
                n_rx_cnt  = '0;
                n_csum    = i_byte;
                n_phase   = (i_byte == JUMBO_LEN) ? PH_CODE_JUMBO : PH_CODE_V1;
            end
            PH_CODE_V1: begin
                n_code  = {8'd0, i_byte};
                n_csum  = r_csum ^ i_byte;
                n_phase = (r_exp_len != '0) ? PH_PAY_V1 : PH_CSUM_V1;
            end
            PH_CODE_JUMBO: begin
                n_code  = {8'd0, i_byte};
                n_csum  = r_csum ^ i_byte;
                n_phase = PH_JLEN_LO;
            end
            PH_JLEN_LO: begin
                n_exp_len = {8'd0, i_byte};
                n_csum    = r_csum ^ i_byte;
                n_phase   = PH_JLEN_HI;
            end
            PH_JLEN_HI: begin
                n_exp_len = len_jumbo;
                n_csum    = r_csum ^ i_byte;
                n_rx_cnt  = '0;
                n_phase   = (len_jumbo != '0) ? PH_PAY_V1 : PH_CSUM_V1;
            end
            PH_CODE_V2_LO: begin
                n_code  = {8'd0, i_byte};
                n_csum  = crc_b;
                n_phase = PH_CODE_V2_HI;
            end
            PH_CODE_V2_HI: begin
                n_code  = {i_byte, r_code[7:0]};
                n_csum  = crc_b;
                n_phase = PH_LEN_V2_LO;
            end
            PH_LEN_V2_LO: begin
                n_exp_len = {8'd0, i_byte};
                n_csum    = crc_b;
                n_phase   = PH_LEN_V2_HI;
            end
            PH_LEN_V2_HI: begin
                n_exp_len = len_v2;
                n_csum    = crc_b;
                n_rx_cnt  = '0;
                if (len_v2 > i_max_v2) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = (len_v2 != '0) ? PH_PAY_V2 : PH_CSUM_V2;
                end
            end
            PH_PAY_V1, PH_PAY_V2: begin
                o_res_valid = 1'b1;
                n_csum      = (r_phase == PH_PAY_V2) ? crc_b : (r_csum ^ i_byte);
                n_rx_cnt    = cnt_inc;
                if (cnt_inc >= r_exp_len) begin
                    n_phase = (r_phase == PH_PAY_V2) ? PH_CSUM_V2 : PH_CSUM_V1;
                end
            end
            PH_CSUM_V1, PH_CSUM_V2: begin
                o_res_valid = 1'b1;
                o_res.kind  = (r_csum == i_byte) ? msp_pkg::KIND_CSUM_OK
                                                 : msp_pkg::KIND_CSUM_BAD;
                n_phase     = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_exp_len <= '0;
            r_rx_cnt  <= '0;
            r_code    <= '0;
            r_csum    <= '0;
            r_flag    <= '0;
            r_dir     <= 1'b0;
            r_unsup   <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_exp_len <= n_exp_len;
            r_rx_cnt  <= n_rx_cnt;
            r_code    <= n_code;
            r_csum    <= n_csum;
            r_flag    <= n_flag;
            r_dir     <= n_dir;
            r_unsup   <= n_unsup;
        end
    end

endmodule

@@ src/msp_v1_v2_frame_decoder_core.sv @@
`timescale 1ns / 1ps
// Top level of the MSP v1/v2 frame decoder: input register, parser, result register.
// Depends on msp_pkg, msp_cfg and msp_parser.

// Takes one received byte per word and decodes MSP v1 ("$M", including jumbo
// frames) and v2 ("$X") frames. Each payload byte leaves as a result word with its
// index; the checksum byte ends the frame with a good or bad verdict. Bytes that
// carry header fields give no result, and v2 frames longer than max_v2_payload
// (APB word address 0, reset 4096) are dropped without a result. The block takes
// one byte every cycle while results are taken: a byte is registered on entry, the
// parse state and the XOR or CRC-8 checksum advance as it leaves the input
// register, and any result is registered in the result register. A stalled result
// holds the byte in the input register; once that register is full too, input stalls.
module msp_v1_v2_frame_decoder_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [msp_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [msp_pkg::KIND_W-1:0]    o_result_kind,
    output logic [msp_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic [msp_pkg::LEN_W-1:0]     o_byte_index,
    output logic [msp_pkg::LEN_W-1:0]     o_command_code,
    output logic [msp_pkg::LEN_W-1:0]     o_payload_length,
    output logic                          o_is_version2,
    output logic                          o_direction,
    output logic                          o_unsupported,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msp_pkg::APB_AW-1:0]    paddr,
    input  logic [msp_pkg::APB_DW-1:0]    pwdata,
    output logic [msp_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    logic [msp_pkg::LEN_W-1:0]  max_v2;
    logic                       r_in_valid;
    logic [msp_pkg::BYTE_W-1:0] r_in_byte;
    logic                       r_out_valid;
    msp_pkg::t_result           r_out;
    logic                       out_free;
    logic                       advance;
    logic                       res_valid;
    msp_pkg::t_result           res;

    msp_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_max_v2 (max_v2)
    );

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || advance;

    msp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_byte      (r_in_byte),
        .i_max_v2    (max_v2),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_kind    = r_out.kind;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_byte_index     = r_out.byte_index;
    assign o_command_code   = r_out.command_code;
    assign o_payload_length = r_out.payload_length;
    assign o_is_version2    = r_out.is_version2;
    assign o_direction      = r_out.direction;
    assign o_unsupported    = r_out.unsupported;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte))
        else $error("input word lost while parser stalled");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_in_valid && r_out_valid && !i_ready)
        else $error("input stalled without a full pipeline");

    a_kind_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result_kind == msp_pkg::KIND_PAYLOAD ||
                     o_result_kind == msp_pkg::KIND_CSUM_OK ||
                     o_result_kind == msp_pkg::KIND_CSUM_BAD))
        else $error("illegal result kind");

    a_pay_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind == msp_pkg::KIND_PAYLOAD
            |-> o_byte_index < o_payload_length)
        else $error("payload index beyond declared length");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for msp_v1_v2_frame_decoder_core: bytes in, result words out.
// Depends on msp_pkg and the core; a built-in MSP v1/v2 parser model predicts every result word.
module tb;

    localparam int unsigned  PHASES         = 6;
    localparam int unsigned  ITEMS_PER_RUN  = 220;
    localparam int unsigned  DRAIN_CYCLES   = 8;
    localparam int unsigned  HOLD_CYCLES    = 200;
    localparam int unsigned  CYCLE_LIMIT    = 600000;
    localparam int unsigned  MAX_REPORTS    = 10;
    localparam int unsigned  AW             = msp_pkg::APB_AW;
    localparam int unsigned  DW             = msp_pkg::APB_DW;
    localparam int unsigned  KW             = msp_pkg::KIND_W;
    localparam logic [7:0]   CRC_POLY       = 8'hD5;
    localparam logic [7:0]   CH_DOLLAR      = 8'h24;
    localparam logic [7:0]   CH_M           = 8'h4D;
    localparam logic [7:0]   CH_X           = 8'h58;
    localparam logic [7:0]   CH_GT          = 8'h3E;
    localparam logic [7:0]   CH_LT          = 8'h3C;
    localparam logic [7:0]   CH_BANG        = 8'h21;
    localparam logic [7:0]   JUMBO_MARK     = 8'hFF;
    localparam logic         FREE           = 1'b0;
    localparam logic         PIN            = 1'b1;
    localparam logic [KW-1:0] K_PAY         = msp_pkg::KIND_PAYLOAD;
    localparam logic [KW-1:0] K_OK          = msp_pkg::KIND_CSUM_OK;
    localparam logic [KW-1:0] K_BAD         = msp_pkg::KIND_CSUM_BAD;
    localparam logic [AW-1:0] MAX_V2_ADDR   = AW'(4 * int'(msp_pkg::REG_MAX_V2));

    typedef enum logic [4:0] {
        ST_HUNT, ST_PROTO, ST_DIR_V1, ST_DIR_V2, ST_FLAG_V2, ST_LEN_V1, ST_CODE_V1,
        ST_CODE_JUMBO, ST_JLEN_LO, ST_JLEN_HI, ST_PAY_V1, ST_CODE_V2_LO, ST_CODE_V2_HI,
        ST_LEN_V2_LO, ST_LEN_V2_HI, ST_PAY_V2, ST_CSUM_V1, ST_CSUM_V2
    } t_parse;

    typedef struct packed {
        logic [7:0]        rx;
        logic              pinned;
        logic [KW-1:0]     kind;
    } t_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [msp_pkg::BYTE_W-1:0]    i_rx_byte;
    logic                          o_valid;
    logic                          i_ready;
    logic [KW-1:0]                 o_result_kind;
    logic [msp_pkg::BYTE_W-1:0]    o_payload_byte;
    logic [msp_pkg::LEN_W-1:0]     o_byte_index;
    logic [msp_pkg::LEN_W-1:0]     o_command_code;
    logic [msp_pkg::LEN_W-1:0]     o_payload_length;
    logic                          o_is_version2;
    logic                          o_direction;
    logic                          o_unsupported;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [AW-1:0]                 paddr;
    logic [DW-1:0]                 pwdata;
    logic [DW-1:0]                 prdata;
    logic                          pready;

    // parser model state
    t_parse              st        = ST_HUNT;
    logic [15:0]         want_len  = '0;
    logic [15:0]         got_cnt   = '0;
    logic [15:0]         msg_code  = '0;
    logic [7:0]          csum      = '0;
    logic                dir_bit   = 1'b0;
    logic                unsup_bit = 1'b0;
    logic [15:0]         v2_limit  = msp_pkg::MAX_V2_RESET;

    msp_pkg::t_result    expected_words[$];
    logic [7:0]          frame_bytes[$];
    int unsigned         fault_count = 0;
    int unsigned         cycle_count = 0;
    int unsigned         send_pct    = 0;
    int unsigned         recv_pct    = 0;
    int unsigned         hold_asks   = 0;
    int unsigned         hold_seen   = 0;
    int unsigned         hold_left   = 0;

    t_row dir_rows [0:33] = '{
        '{CH_DOLLAR, FREE, K_PAY}, '{CH_DOLLAR, FREE, K_PAY},
        '{CH_DOLLAR, FREE, K_PAY}, '{CH_M, FREE, K_PAY},
        '{CH_BANG, FREE, K_PAY}, '{8'h00, FREE, K_PAY},
        '{8'hFF, FREE, K_PAY}, '{8'hFF, PIN, K_OK},
        '{CH_DOLLAR, FREE, K_PAY}, '{CH_M, FREE, K_PAY},
        '{CH_LT, FREE, K_PAY}, '{JUMBO_MARK, FREE, K_PAY},
        '{8'h05, FREE, K_PAY}, '{8'h00, FREE, K_PAY},
        '{8'h00, FREE, K_PAY}, '{8'h00, PIN, K_BAD},
        '{CH_DOLLAR, FREE, K_PAY}, '{CH_X, FREE, K_PAY},
        '{8'h3F, FREE, K_PAY}, '{8'h00, FREE, K_PAY},
        '{8'h34, FREE, K_PAY}, '{8'h12, FREE, K_PAY},
        '{8'hFF, FREE, K_PAY}, '{8'hFF, FREE, K_PAY},
        '{CH_DOLLAR, FREE, K_PAY}, '{CH_X, FREE, K_PAY},
        '{CH_GT, FREE, K_PAY}, '{8'hFF, FREE, K_PAY},
        '{8'hFF, FREE, K_PAY}, '{8'hFF, FREE, K_PAY},
        '{8'h01, FREE, K_PAY}, '{8'h00, FREE, K_PAY},
        '{8'h80, PIN, K_PAY}, '{8'h00, FREE, K_PAY}
    };

    msp_v1_v2_frame_decoder_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_kind    (o_result_kind),
        .o_payload_byte   (o_payload_byte),
        .o_byte_index     (o_byte_index),
        .o_command_code   (o_command_code),
        .o_payload_length (o_payload_length),
        .o_is_version2    (o_is_version2),
        .o_direction      (o_direction),
        .o_unsupported    (o_unsupported),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] crc8_d5(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] x;
        x = c ^ b;
        for (int k = 0; k < 8; k++) x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
        return x;
    endfunction

    function automatic void fill_word(output msp_pkg::t_result r, input logic [KW-1:0] kind,
                                      input logic [7:0] b, input logic v2);
        r.kind           = kind;
        r.payload_byte   = b;
        r.byte_index     = got_cnt;
        r.command_code   = msg_code;
        r.payload_length = want_len;
        r.is_version2    = v2;
        r.direction      = dir_bit;
        r.unsupported    = unsup_bit;
    endfunction

    // advance the parser model by one byte; return 1 when a word is due
    function automatic bit parse_byte(input logic [7:0] b, output msp_pkg::t_result r);
        logic v2;
        r = '0;
        unique case (st)
            ST_HUNT: begin
                if (b == CH_DOLLAR) begin
                    csum = '0;
                    st   = ST_PROTO;
                end
            end
            ST_PROTO: st = (b == CH_M) ? ST_DIR_V1 : (b == CH_X) ? ST_DIR_V2 : ST_HUNT;
            ST_DIR_V1, ST_DIR_V2: begin
                unsup_bit = 1'b0;
                if (b == CH_GT) dir_bit = 1'b1;
                else if (b == CH_LT) dir_bit = 1'b0;
                else if (b == CH_BANG) unsup_bit = 1'b1;
                st = (st == ST_DIR_V1) ? ST_LEN_V1 : ST_FLAG_V2;
            end
            ST_FLAG_V2: begin
                csum = crc8_d5(8'h00, b);
                st   = ST_CODE_V2_LO;
            end
            ST_LEN_V1: begin
                want_len = 16'(b);
                got_cnt  = '0;
                csum     = b;
                st       = (b == JUMBO_MARK) ? ST_CODE_JUMBO : ST_CODE_V1;
            end
            ST_CODE_V1: begin
                msg_code = 16'(b);
                csum     = csum ^ b;
                st       = (want_len != 0) ? ST_PAY_V1 : ST_CSUM_V1;
            end
            ST_CODE_JUMBO: begin
                msg_code = 16'(b);
                csum     = csum ^ b;
                st       = ST_JLEN_LO;
            end
            ST_JLEN_LO: begin
                want_len = 16'(b);
                csum     = csum ^ b;
                st       = ST_JLEN_HI;
            end
            ST_JLEN_HI: begin
                want_len = {b, want_len[7:0]};
                csum     = csum ^ b;
                got_cnt  = '0;
                st       = (want_len != 0) ? ST_PAY_V1 : ST_CSUM_V1;
            end
            ST_CODE_V2_LO: begin
                msg_code = 16'(b);
                csum     = crc8_d5(csum, b);
                st       = ST_CODE_V2_HI;
            end
            ST_CODE_V2_HI: begin
                msg_code = {b, msg_code[7:0]};
                csum     = crc8_d5(csum, b);
                st       = ST_LEN_V2_LO;
            end
            ST_LEN_V2_LO: begin
                want_len = 16'(b);
                csum     = crc8_d5(csum, b);
                st       = ST_LEN_V2_HI;
            end
            ST_LEN_V2_HI: begin
                want_len = {b, want_len[7:0]};
                csum     = crc8_d5(csum, b);
                got_cnt  = '0;
                if (want_len > v2_limit) st = ST_HUNT;
                else st = (want_len != 0) ? ST_PAY_V2 : ST_CSUM_V2;
            end
            ST_PAY_V1, ST_PAY_V2: begin
                v2 = (st == ST_PAY_V2);
                fill_word(r, K_PAY, b, v2);
                csum    = v2 ? crc8_d5(csum, b) : (csum ^ b);
                got_cnt = got_cnt + 16'd1;
                if (got_cnt >= want_len) st = v2 ? ST_CSUM_V2 : ST_CSUM_V1;
                return 1'b1;
            end
            ST_CSUM_V1, ST_CSUM_V2: begin
                v2 = (st == ST_CSUM_V2);
                fill_word(r, (csum == b) ? K_OK : K_BAD, b, v2);
                st = ST_HUNT;
                return 1'b1;
            end
            default: st = ST_HUNT;
        endcase
        return 1'b0;
    endfunction

    // assemble one frame into frame_bytes, mostly well formed
    function automatic void build_frame(input logic [15:0] limit);
        int unsigned form;
        int unsigned pick;
        int unsigned len;
        logic [7:0]  dirc;
        logic [7:0]  ck;
        logic [7:0]  pay;
        logic [15:0] code;
        logic [15:0] len16;
        bit          oversize;
        frame_bytes.delete();
        form = $urandom_range(99);
        pick = $urandom_range(9);
        dirc = (pick < 3) ? CH_GT : (pick < 6) ? CH_LT : (pick < 8) ? CH_BANG
                                                   : 8'($urandom_range(255));
        pick = $urandom_range(99);
        len  = (pick < 3) ? $urandom_range(41, 300) :
               (pick < 13) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        code = 16'($urandom_range(65535));
        oversize = 1'b0;
        frame_bytes.push_back(CH_DOLLAR);
        if (form < 45) begin
            if (len > 254) len = 254;
            len16 = 16'(len);
            ck = len16[7:0] ^ code[7:0];
            frame_bytes.push_back(CH_M);
            frame_bytes.push_back(dirc);
            frame_bytes.push_back(len16[7:0]);
            frame_bytes.push_back(code[7:0]);
        end else if (form < 60) begin
            len16 = 16'(len);
            ck = JUMBO_MARK ^ code[7:0] ^ len16[7:0] ^ len16[15:8];
            frame_bytes.push_back(CH_M);
            frame_bytes.push_back(dirc);
            frame_bytes.push_back(JUMBO_MARK);
            frame_bytes.push_back(code[7:0]);
            frame_bytes.push_back(len16[7:0]);
            frame_bytes.push_back(len16[15:8]);
        end else begin
            oversize = (limit != 16'hFFFF) && ($urandom_range(99) < 15);
            if (oversize) len = $urandom_range(int'(limit) + 1, 65535);
            else if (len > limit) len = limit;
            len16 = 16'(len);
            pay = 8'($urandom_range(255));
            frame_bytes.push_back(CH_X);
            frame_bytes.push_back(dirc);
            frame_bytes.push_back(pay);
            frame_bytes.push_back(code[7:0]);
            frame_bytes.push_back(code[15:8]);
            frame_bytes.push_back(len16[7:0]);
            frame_bytes.push_back(len16[15:8]);
            ck = crc8_d5(8'h00, pay);
            ck = crc8_d5(ck, code[7:0]);
            ck = crc8_d5(ck, code[15:8]);
            ck = crc8_d5(ck, len16[7:0]);
            ck = crc8_d5(ck, len16[15:8]);
        end
        if (!oversize) begin
            for (int i = 0; i < int'(len); i++) begin
                pay = 8'($urandom_range(255));
                frame_bytes.push_back(pay);
                ck = (form < 60) ? (ck ^ pay) : crc8_d5(ck, pay);
            end
            if ($urandom_range(99) < 15) ck = ck ^ 8'($urandom_range(1, 255));
            frame_bytes.push_back(ck);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic pinned,
                             input logic [KW-1:0] kind);
        msp_pkg::t_result r;
        bit               due;
        while ((send_pct != 0) && ($urandom_range(99) < send_pct)) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        due = parse_byte(b, r);
        if (due || pinned) begin
            if (pinned) r.kind = kind;
            expected_words.push_back(r);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [AW-1:0] a, input logic [DW-1:0] d);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [AW-1:0] a, output logic [DW-1:0] d);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        d = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        msp_pkg::t_result act;
        msp_pkg::t_result exp_w;
        if (i_rst_n && o_valid && i_ready) begin
            act = '{o_result_kind, o_payload_byte, o_byte_index, o_command_code,
                    o_payload_length, o_is_version2, o_direction, o_unsupported};
            if (expected_words.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("unexpected word: kind %0d byte %h index %0d",
                             act.kind, act.payload_byte, act.byte_index);
            end else begin
                exp_w = expected_words.pop_front();
                if (act !== exp_w) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display({"word mismatch (exp/act): kind %0d/%0d byte %h/%h ",
                                  "index %0d/%0d code %h/%h len %0d/%0d v2 %b/%b ",
                                  "dir %b/%b unsup %b/%b"},
                                 exp_w.kind, act.kind, exp_w.payload_byte,
                                 act.payload_byte, exp_w.byte_index, act.byte_index,
                                 exp_w.command_code, act.command_code,
                                 exp_w.payload_length, act.payload_length,
                                 exp_w.is_version2, act.is_version2,
                                 exp_w.direction, act.direction,
                                 exp_w.unsupported, act.unsupported);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("msp_v1_v2_frame_decoder_core verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [DW-1:0]     rd;
        logic [15:0]       cfg;
        logic [7:0]        nb;
        int unsigned       sent;
        int unsigned       pick;
        int unsigned       cut;
        bit                held;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_rx_byte = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < 34; i++)
            send_byte(dir_rows[i].rx, dir_rows[i].pinned, dir_rows[i].kind);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin cfg = 16'hFFFF;                      send_pct = 0;  recv_pct = 0;  end
                1: begin cfg = 16'h0000;                      send_pct = 86; recv_pct = 0;  end
                2: begin cfg = 16'd5;                         send_pct = 0;  recv_pct = 86; end
                3: begin cfg = 16'($urandom_range(6, 40));    send_pct = 30; recv_pct = 30; end
                4: begin cfg = msp_pkg::MAX_V2_RESET;         send_pct = 0;  recv_pct = 0;  end
                default: begin
                    cfg = 16'($urandom_range(65535));
                    send_pct = 30;
                    recv_pct = 30;
                end
            endcase
            apb_write(MAX_V2_ADDR, DW'(cfg));
            v2_limit = cfg;
            apb_read(MAX_V2_ADDR, rd);
            if (rd[15:0] !== cfg) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("max_v2_payload readback %h, wrote %h", rd[15:0], cfg);
            end

            sent = 0;
            held = 1'b0;
            while (sent < ITEMS_PER_RUN) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    repeat ($urandom_range(1, 3)) begin
                        case ($urandom_range(3))
                            0: nb = CH_DOLLAR;
                            1: nb = CH_M;
                            2: nb = CH_X;
                            default: nb = 8'($urandom_range(255));
                        endcase
                        send_byte(nb, FREE, K_PAY);
                    end
                end else begin
                    build_frame(v2_limit);
                    // drop the tail to leave a broken frame
                    if (pick < 16 && frame_bytes.size() > 1) begin
                        cut = $urandom_range(1, frame_bytes.size() - 1);
                        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
                    end
                    foreach (frame_bytes[k]) send_byte(frame_bytes[k], FREE, K_PAY);
                    sent += frame_bytes.size();
                end
                if (p == 0 && !held && sent >= ITEMS_PER_RUN / 2) begin
                    hold_asks++;
                    held = 1'b1;
                end
            end
            wait_idle();
        end

        if (fault_count == 0 && expected_words.size() == 0)
            $display("msp_v1_v2_frame_decoder_core verification clean");
        else
            $display("msp_v1_v2_frame_decoder_core verification failed");
        $finish;
    end

endmodule
